// ===== rtl/core/blt_pkg.sv =====
// ----------------------------------------------------------------------------
// blt_pkg
// Shared constants for the Bresenham line tile walker.
// ----------------------------------------------------------------------------
package blt_pkg;

  // error term needs two bits over the coordinate width (sign and doubling)
  localparam int ERR_GUARD_BITS = 2;

  // entries in the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/blt_front.sv =====
// ----------------------------------------------------------------------------
// blt_front
// Takes an endpoint pair and precomputes deltas, step signs and the
// starting error term; holds the resulting job for the queue.
// ----------------------------------------------------------------------------
module blt_front #(
  parameter int CB = 6,
  parameter int EW = CB + blt_pkg::ERR_GUARD_BITS,
  parameter int JW = 6 * CB + 2 + EW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [4*CB-1:0] in_data,
  output logic            job_valid,
  input  logic            job_ready,
  output logic [JW-1:0]   job
);

  logic [CB-1:0] sx, sy, ex, ey;
  logic [CB-1:0] dx, dy;
  logic          sx_neg, sy_neg;
  logic [EW-1:0] err0;
  logic          job_vld;
  logic [JW-1:0] job_reg;

  assign sx = in_data[CB-1:0];
  assign sy = in_data[2*CB-1:CB];
  assign ex = in_data[3*CB-1:2*CB];
  assign ey = in_data[4*CB-1:3*CB];

  always_comb begin
    dx     = (ex > sx) ? ex - sx : sx - ex;
    dy     = (ey > sy) ? ey - sy : sy - ey;
    sx_neg = !(sx < ex);
    sy_neg = !(sy < ey);
    err0   = EW'(dx) - EW'(dy);
  end

  assign in_ready  = !job_vld || job_ready;
  assign job_valid = job_vld;
  assign job       = job_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_vld <= 1'b0;
    end else if (in_ready) begin
      job_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job_reg <= {err0, sy_neg, sx_neg, dy, dx, ey, ex, sy, sx};
    end
  end

endmodule

// ===== rtl/core/blt_queue.sv =====
// ----------------------------------------------------------------------------
// blt_queue
// Small register FIFO carrying precomputed line jobs to the walker.
// ----------------------------------------------------------------------------
module blt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/blt_back.sv =====
// ----------------------------------------------------------------------------
// blt_back
// Bresenham stepper: loads a job, then emits one tile per cycle into an
// output register, unless out_ready stalls it, until the end point is reached.
// ----------------------------------------------------------------------------
module blt_back #(
  parameter int CB = 6,
  parameter int EW = CB + blt_pkg::ERR_GUARD_BITS,
  parameter int JW = 6 * CB + 2 + EW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  logic [JW-1:0] job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB-1:0] out_x,
  output logic [CB-1:0] out_y,
  output logic          out_last
);

  logic [CB-1:0] cur_x, cur_y, tgt_x, tgt_y, dx, dy;
  logic          sx_neg, sy_neg;
  logic [EW-1:0] err;
  logic          busy;
  logic          adv, at_end;
  logic          step_x, step_y;
  logic signed [EW:0] e2, ndy, pdx;
  logic [EW-1:0] err_next;
  logic          ovld;

  assign job_ready = !busy;
  assign adv       = busy && (!ovld || out_ready);
  assign at_end    = (cur_x == tgt_x) && (cur_y == tgt_y);
  assign out_valid = ovld;

  always_comb begin
    e2       = {err, 1'b0};
    ndy      = -$signed((EW+1)'(dy));
    pdx      = $signed((EW+1)'(dx));
    step_x   = e2 > ndy;
    step_y   = e2 < pdx;
    err_next = err - (step_x ? EW'(dy) : '0) + (step_y ? EW'(dx) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovld <= 1'b0;
    end else begin
      if (!busy && job_valid) begin
        busy <= 1'b1;
      end else if (adv && at_end) begin
        busy <= 1'b0;
      end
      if (adv) begin
        ovld <= 1'b1;
      end else if (out_ready) begin
        ovld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      {err, sy_neg, sx_neg, dy, dx, tgt_y, tgt_x, cur_y, cur_x} <= job;
    end else if (adv && !at_end) begin
      err <= err_next;
      if (step_x) begin
        cur_x <= sx_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (step_y) begin
        cur_y <= sy_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= cur_x;
      out_y    <= cur_y;
      out_last <= at_end;
    end
  end

endmodule

// ===== rtl/core/bresenham_line_tiles_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_tiles_core
// Path: front register, job queue, walker load, walker output register.
// Throughput: a line of N = max(|dx|,|dy|)+1 tiles needs one load and then
//   one tile per cycle, unless m_tready stalls, in the back's single stepper.
// The front part and a 2-entry job queue take up to three further lines.
// Reset: synchronous, clears all valid flags and the walker busy flag.
// ----------------------------------------------------------------------------
module bresenham_line_tiles_core #(
  parameter int COORD_BITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tile_x, tile_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // last_tile
  output logic                   m_tlast
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + blt_pkg::ERR_GUARD_BITS;
  localparam int JW = 6 * CB + 2 + EW;
  localparam int OW = ((2 * CB + 7) / 8) * 8;

  logic          f_valid, f_ready;
  logic [JW-1:0] f_job;
  logic          q_valid, q_ready;
  logic [JW-1:0] q_job;
  logic [CB-1:0] tx, ty;

  blt_front #(.CB(CB), .EW(EW), .JW(JW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[4*CB-1:0]),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  blt_queue #(.W(JW), .DEPTH(blt_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  blt_back #(.CB(CB), .EW(EW), .JW(JW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (tx),
    .out_y     (ty),
    .out_last  (m_tlast)
  );

  assign m_tdata = OW'({ty, tx});

endmodule
